/* hw/rtl/itph_pkg.sv */
// ----------------------------------------------------------------------------
// itph_pkg
// Shared types and constants for the IR timing pattern hash.
// ----------------------------------------------------------------------------
package itph_pkg;

  localparam int unsigned TICK_WIDTH_DEF = 16;

  localparam logic [31:0] FNV_PRIME = 32'd16777619;
  localparam logic [31:0] FNV_BASIS = 32'd2166136261;

  // new*CMP_SCALE_HI vs old*CMP_SCALE_LO, and the reverse, give the window: -20% / +25%
  localparam int unsigned CMP_SCALE_HI = 10;
  localparam int unsigned CMP_SCALE_LO = 8;

  localparam int unsigned HASH_W      = 32;
  localparam int unsigned CNT_W       = 3;
  localparam logic [2:0]  MIN_ENTRIES = 3'd6;
  localparam logic [2:0]  COUNT_SAT   = 3'd6;
  localparam logic [2:0]  FIRST_FOLD  = 3'd3;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = 2;

  typedef enum logic [1:0] {
    SYM_SHORTER = 2'd0,
    SYM_SAME    = 2'd1,
    SYM_LONGER  = 2'd2
  } sym_t;

  // one classified entry passed from front to back
  typedef struct packed {
    sym_t sym;
    logic fold;      // symbol goes into the hash
    logic last;      // frame ends here, emit a result
    logic frame_ok;  // frame reached the minimum entry count
  } op_t;

endpackage

/* hw/rtl/ir_timing_pattern_hash.sv */
// ----------------------------------------------------------------------------
// ir_timing_pattern_hash
// Hashes the shape of an IR mark/space frame into a 32-bit FNV-1 value.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  in_*    | in  | tvalid/tready      | tdata: duration_ticks, tlast: last_entry
//  out_*   | out | tvalid/tready      | tdata: hash_value, tuser: hash_valid
//
//  One duration per cycle sustained while the queue is not full; the hash
//  multiply (one 32x32 product into the accumulator) runs once per cycle in the back end.
//  A result's last entry passes through the queue and then the output register.
//  A four-entry queue lets input continue while a result waits on out_tready.
//  Synchronous active-low reset; the block is ready the cycle after reset.
// ----------------------------------------------------------------------------
module ir_timing_pattern_hash #(
  parameter int unsigned TICK_WIDTH = itph_pkg::TICK_WIDTH_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_tvalid,
  output logic                                    in_tready,
  input  logic [((TICK_WIDTH+7)/8)*8-1:0]         in_tdata,  // [TICK_WIDTH-1:0] duration_ticks
  input  logic                                    in_tlast,
  output logic                                    out_tvalid,
  input  logic                                    out_tready,
  output logic [itph_pkg::HASH_W-1:0]             out_tdata, // [31:0] hash_value
  output logic [0:0]                              out_tuser  // [0] hash_valid
);

  logic          in_fire;
  logic          push, full, pop, not_empty;
  itph_pkg::op_t push_op, head_op;
  logic          out_ok;

  assign in_tready = !full;
  assign in_fire   = in_tvalid && in_tready;

  itph_front #(
    .TICK_WIDTH (TICK_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .duration (in_tdata[TICK_WIDTH-1:0]),
    .last     (in_tlast),
    .push     (push),
    .push_op  (push_op)
  );

  itph_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_op   (push_op),
    .full      (full),
    .pop       (pop),
    .not_empty (not_empty),
    .head_op   (head_op)
  );

  itph_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .op_avail   (not_empty),
    .op         (head_op),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_hash   (out_tdata),
    .out_ok     (out_ok)
  );

  assign out_tuser = out_ok;

endmodule

/* hw/rtl/itph_front.sv */
// ----------------------------------------------------------------------------
// itph_front
// Accepts durations, keeps the two previous entries and the entry count,
// and turns each entry into a hash operation.
// ----------------------------------------------------------------------------
module itph_front #(
  parameter int unsigned TICK_WIDTH = itph_pkg::TICK_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_fire,
  input  logic [TICK_WIDTH-1:0] duration,
  input  logic                  last,
  output logic                  push,
  output itph_pkg::op_t         push_op
);

  localparam int unsigned PW = TICK_WIDTH + 4;

  logic [TICK_WIDTH-1:0]      prev1_r, prev2_r;
  logic [itph_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [PW-1:0]              new_hi, new_lo, old_hi, old_lo;

  always_comb begin
    new_hi = PW'(duration) * PW'(itph_pkg::CMP_SCALE_HI);
    new_lo = PW'(duration) * PW'(itph_pkg::CMP_SCALE_LO);
    old_hi = PW'(prev2_r)  * PW'(itph_pkg::CMP_SCALE_HI);
    old_lo = PW'(prev2_r)  * PW'(itph_pkg::CMP_SCALE_LO);

    if (new_hi < old_lo) begin
      push_op.sym = itph_pkg::SYM_SHORTER;
    end else if (old_hi < new_lo) begin
      push_op.sym = itph_pkg::SYM_LONGER;
    end else begin
      push_op.sym = itph_pkg::SYM_SAME;
    end
    push_op.fold     = (cnt_r >= itph_pkg::FIRST_FOLD);
    push_op.last     = last;
    push_op.frame_ok = (cnt_r >= (itph_pkg::MIN_ENTRIES - 3'd1));

    // entries that neither fold nor end the frame need no back-end work
    push = in_fire && (push_op.fold || last);

    if (last) begin
      cnt_nxt = '0;
    end else if (cnt_r < itph_pkg::COUNT_SAT) begin
      cnt_nxt = cnt_r + 3'd1;
    end else begin
      cnt_nxt = cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (in_fire) begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      prev2_r <= prev1_r;
      prev1_r <= duration;
    end
  end

endmodule

/* hw/rtl/itph_fifo.sv */
// ----------------------------------------------------------------------------
// itph_fifo
// Small queue of hash operations between front and back.
// ----------------------------------------------------------------------------
module itph_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  itph_pkg::op_t push_op,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output itph_pkg::op_t head_op
);

  itph_pkg::op_t                 mem_r [itph_pkg::FIFO_DEPTH];
  logic [itph_pkg::FIFO_AW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [itph_pkg::FIFO_AW:0]    count_r;

  assign full      = (count_r == (itph_pkg::FIFO_AW+1)'(itph_pkg::FIFO_DEPTH));
  assign not_empty = (count_r != '0);
  assign head_op   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

/* hw/rtl/itph_back.sv */
// ----------------------------------------------------------------------------
// itph_back
// Folds symbols into the FNV-1 hash and holds the result register.
// ----------------------------------------------------------------------------
module itph_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        op_avail,
  input  itph_pkg::op_t               op,
  output logic                        pop,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [itph_pkg::HASH_W-1:0] out_hash,
  output logic                        out_ok
);

  logic [itph_pkg::HASH_W-1:0] hash_r, hash_nxt, prod;
  logic                        out_valid_r;
  logic [itph_pkg::HASH_W-1:0] out_hash_r;
  logic                        out_ok_r;
  logic                        slot_free;

  assign slot_free = !out_valid_r || out_tready;
  assign pop       = op_avail && (!op.last || slot_free);

  always_comb begin
    prod = hash_r * itph_pkg::FNV_PRIME;
    if (op.fold) begin
      hash_nxt = prod ^ itph_pkg::HASH_W'(op.sym);
    end else begin
      hash_nxt = hash_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r      <= itph_pkg::FNV_BASIS;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        hash_r <= op.last ? itph_pkg::FNV_BASIS : hash_nxt;
      end
      if (pop && op.last) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && op.last) begin
      out_hash_r <= op.frame_ok ? hash_nxt : '0;
      out_ok_r   <= op.frame_ok;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_hash   = out_hash_r;
  assign out_ok     = out_ok_r;

endmodule
